### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the decoder RTL
// Clocked, reset-qualified property forms used by the block's checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### src/qoi_pkg.sv
// ---------------------------------------------------------------------------
// QOI decoder package
// Chunk codes, parser kinds, pixel type and the controller/datapath links.
// ---------------------------------------------------------------------------
package qoi_pkg;

    localparam int IdxW       = 6;
    localparam int IndexDepth = 1 << IdxW;
    localparam int CfgW       = 3;

    // Chunk opcodes and two-bit tags
    localparam logic [7:0] OP_RGB    = 8'hFE;
    localparam logic [7:0] OP_RGBA   = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic [7:0]      ALPHA_OPAQUE = 8'hFF;
    localparam logic [CfgW-1:0] CH_RGBA      = 3'd4;
    localparam logic [CfgW-1:0] CH_RESET     = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RGB,
        KIND_RGBA,
        KIND_LUMA
    } qoi_kind_t;

    // What a decoded byte asks of the controller
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LOOKUP,
        ACT_STORE
    } qoi_act_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    typedef struct packed {
        logic take;
        logic decode;
        logic load_index;
        logic store;
        logic run_step;
    } qoi_cmd_t;

    typedef struct packed {
        qoi_act_t action;
        logic     run_done;
    } qoi_sts_t;

    // Standard QOI hash, (3r + 5g + 7b + 11a) mod 64
    function automatic logic [IdxW-1:0] qoi_hash(pixel_t p);
        logic [IdxW-1:0] h;
        h = p.r[IdxW-1:0] * IdxW'(3) + p.g[IdxW-1:0] * IdxW'(5)
          + p.b[IdxW-1:0] * IdxW'(7) + p.a[IdxW-1:0] * IdxW'(11);
        return h;
    endfunction

endpackage

### src/qoi_if.sv
// ---------------------------------------------------------------------------
// QOI decoder stream interfaces
// Valid/ready channels for chunk bytes in and decoded pixels out.
// ---------------------------------------------------------------------------
interface qoi_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source (output valid, data_byte, image_start, input ready);
    modport sink   (input valid, data_byte, image_start, output ready);
endinterface

interface qoi_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       alpha_used;
    logic       last_of_run;

    modport source (output valid, red, green, blue, alpha, alpha_used, last_of_run,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, alpha_used, last_of_run,
                    output ready);
endinterface

### src/qoi_cfg.sv
// ---------------------------------------------------------------------------
// QOI decoder configuration registers
// APB-style register file holding the channel count.
// ---------------------------------------------------------------------------
module qoi_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [qoi_pkg::CfgW-1:0] channel_count
);
    import qoi_pkg::*;

    localparam logic REG_CHANNEL_COUNT = 1'b0;

    logic [CfgW-1:0] channel_count_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the channel count on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CH_RESET;
        end
        else if (wr_en && (paddr[2] == REG_CHANNEL_COUNT))
        begin
            channel_count_reg <= pwdata[CfgW-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CHANNEL_COUNT)
        begin
            prdata = {{(32-CfgW){1'b0}}, channel_count_reg};
        end
    end

    assign channel_count = channel_count_reg;

endmodule

### src/qoi_ctrl.sv
// ---------------------------------------------------------------------------
// QOI decoder controller
// Sequences accept, decode, index lookup, index store and pixel emission.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    output logic              pixel_valid,
    input  logic              pixel_ready,
    input  qoi_pkg::qoi_sts_t sts,
    output qoi_pkg::qoi_cmd_t cmd
);
    import qoi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOKUP,
        S_STORE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   take;

    assign take = byte_valid && in_ready_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.action)
                    ACT_LOOKUP: state_next = S_LOOKUP;
                    ACT_STORE:  state_next = S_STORE;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_LOOKUP: state_next = S_STORE;
            S_STORE:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (pixel_ready && sts.run_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and the handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_EMIT);
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.take       = take;
        cmd.decode     = (state_reg == S_DECODE);
        cmd.load_index = (state_reg == S_LOOKUP);
        cmd.store      = (state_reg == S_STORE);
        cmd.run_step   = (state_reg == S_EMIT) && pixel_ready && !sts.run_done;
    end

    assign byte_ready  = in_ready_reg;
    assign pixel_valid = out_valid_reg;

    `ASSERT_NEVER(a_ready_valid_excl, clk, rst_n, in_ready_reg && out_valid_reg)
    `ASSERT_NEXT(a_take_decodes, clk, rst_n, take, state_reg == S_DECODE)
    `ASSERT_IMPLIES(a_valid_in_emit, clk, rst_n, out_valid_reg, state_reg == S_EMIT)

endmodule

### src/qoi_dp.sv
// ---------------------------------------------------------------------------
// QOI decoder datapath
// Byte parser, current pixel, colour index memory and run counter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               data_byte,
    input  logic                     image_start,
    input  logic [qoi_pkg::CfgW-1:0] channel_count,
    input  qoi_pkg::qoi_cmd_t        cmd,
    output qoi_pkg::qoi_sts_t        sts,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [7:0]               alpha,
    output logic                     alpha_used,
    output logic                     last_of_run
);
    import qoi_pkg::*;

    // Parser and pixel state
    logic [7:0]      byte_reg;
    qoi_kind_t       kind_reg, kind_next;
    logic [2:0]      need_reg, need_next;
    logic [31:0]     partial_reg, partial_next;
    pixel_t          pixel_reg, pixel_next;
    logic [IdxW-1:0] run_left_reg, run_left_next;

    // Colour index
    pixel_t          index_mem [IndexDepth];
    logic [IndexDepth-1:0] index_valid_reg;
    pixel_t          rd_data_reg;
    logic            rd_valid_reg;
    logic [IdxW-1:0] store_slot;

    // Decode results
    qoi_act_t        act_dec;
    qoi_kind_t       kind_dec;
    logic [2:0]      need_dec;
    logic [31:0]     partial_dec;
    pixel_t          pixel_dec;
    logic [IdxW-1:0] run_dec;
    logic [31:0]     shifted;
    logic [2:0]      need_less;
    logic [7:0]      dg, drg, dbg;

    assign shifted    = {partial_reg[23:0], byte_reg};
    assign need_less  = need_reg - 3'd1;
    assign dg         = {2'b00, shifted[13:8]} - 8'd32;
    assign drg        = {4'b0000, shifted[7:4]} - 8'd8;
    assign dbg        = {4'b0000, shifted[3:0]} - 8'd8;
    assign store_slot = qoi_hash(pixel_reg);

    // Decode the held byte against the parser state
    always_comb
    begin
        act_dec     = ACT_NONE;
        kind_dec    = kind_reg;
        need_dec    = need_reg;
        partial_dec = partial_reg;
        pixel_dec   = pixel_reg;
        run_dec     = '0;
        if (kind_reg != KIND_NONE)
        begin
            // Payload byte of a multi-byte chunk
            partial_dec = shifted;
            need_dec    = need_less;
            if (need_less == 3'd0)
            begin
                act_dec     = ACT_STORE;
                kind_dec    = KIND_NONE;
                partial_dec = '0;
                case (kind_reg)
                    KIND_RGB:
                    begin
                        pixel_dec.r = shifted[23:16];
                        pixel_dec.g = shifted[15:8];
                        pixel_dec.b = shifted[7:0];
                    end
                    KIND_RGBA:
                    begin
                        pixel_dec.r = shifted[31:24];
                        pixel_dec.g = shifted[23:16];
                        pixel_dec.b = shifted[15:8];
                        pixel_dec.a = shifted[7:0];
                    end
                    default:
                    begin
                        pixel_dec.r = pixel_reg.r + dg + drg;
                        pixel_dec.g = pixel_reg.g + dg;
                        pixel_dec.b = pixel_reg.b + dg + dbg;
                    end
                endcase
            end
        end
        else if (byte_reg == OP_RGB)
        begin
            kind_dec    = KIND_RGB;
            need_dec    = 3'd3;
            partial_dec = '0;
        end
        else if (byte_reg == OP_RGBA)
        begin
            kind_dec    = KIND_RGBA;
            need_dec    = 3'd4;
            partial_dec = '0;
        end
        else
        begin
            case (byte_reg[7:6])
                TAG_INDEX: act_dec = ACT_LOOKUP;
                TAG_DIFF:
                begin
                    act_dec     = ACT_STORE;
                    pixel_dec.r = pixel_reg.r + {6'd0, byte_reg[5:4]} - 8'd2;
                    pixel_dec.g = pixel_reg.g + {6'd0, byte_reg[3:2]} - 8'd2;
                    pixel_dec.b = pixel_reg.b + {6'd0, byte_reg[1:0]} - 8'd2;
                end
                TAG_LUMA:
                begin
                    kind_dec    = KIND_LUMA;
                    need_dec    = 3'd1;
                    partial_dec = {24'd0, byte_reg};
                end
                default:
                begin
                    act_dec = ACT_STORE;
                    run_dec = byte_reg[IdxW-1:0];
                end
            endcase
        end
    end

    // Select next parser, pixel and run state
    always_comb
    begin
        kind_next     = kind_reg;
        need_next     = need_reg;
        partial_next  = partial_reg;
        pixel_next    = pixel_reg;
        run_left_next = run_left_reg;
        if (cmd.take && image_start)
        begin
            kind_next    = KIND_NONE;
            need_next    = 3'd0;
            partial_next = '0;
            pixel_next   = '{r: 8'd0, g: 8'd0, b: 8'd0, a: ALPHA_OPAQUE};
        end
        if (cmd.decode)
        begin
            kind_next     = kind_dec;
            need_next     = need_dec;
            partial_next  = partial_dec;
            pixel_next    = pixel_dec;
            run_left_next = run_dec;
        end
        if (cmd.load_index)
        begin
            pixel_next = rd_valid_reg ? rd_data_reg : '0;
        end
        if (cmd.run_step)
        begin
            run_left_next = run_left_reg - IdxW'(1);
        end
    end

    // Hold control state and index valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_NONE;
            need_reg        <= 3'd0;
            partial_reg     <= '0;
            pixel_reg       <= '{r: 8'd0, g: 8'd0, b: 8'd0, a: ALPHA_OPAQUE};
            run_left_reg    <= '0;
            index_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            kind_reg     <= kind_next;
            need_reg     <= need_next;
            partial_reg  <= partial_next;
            pixel_reg    <= pixel_next;
            run_left_reg <= run_left_next;
            if (cmd.take && image_start)
            begin
                index_valid_reg <= '0;
            end
            else if (cmd.store)
            begin
                index_valid_reg[store_slot] <= 1'b1;
            end
            if (cmd.decode)
            begin
                rd_valid_reg <= index_valid_reg[byte_reg[IdxW-1:0]];
            end
        end
    end

    // Latch the incoming byte
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg <= data_byte;
        end
    end

    // Colour index memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            index_mem[store_slot] <= pixel_reg;
        end
        if (cmd.decode)
        begin
            rd_data_reg <= index_mem[byte_reg[IdxW-1:0]];
        end
    end

    // Status and pixel payload
    assign sts.action   = act_dec;
    assign sts.run_done = (run_left_reg == '0);

    assign red         = pixel_reg.r;
    assign green       = pixel_reg.g;
    assign blue        = pixel_reg.b;
    assign alpha_used  = (channel_count == CH_RGBA);
    assign alpha       = alpha_used ? pixel_reg.a : 8'd0;
    assign last_of_run = (run_left_reg == '0);

    `ASSERT_NEXT(a_store_marks_valid, clk, rst_n, cmd.store,
                 index_valid_reg[$past(store_slot)])
    `ASSERT_NEVER(a_run_outside_emit, clk, rst_n, cmd.run_step && (run_left_reg == '0))

endmodule

### src/qoi_chunk_stream_decoder.sv
// ---------------------------------------------------------------------------
// QOI chunk stream decoder
// Turns the QOI chunk byte stream into RGBA pixels, one byte per transfer.
// ---------------------------------------------------------------------------
// Feed the chunk stream from the first byte after the file header; raise
// image_start with the first byte of each image to clear the colour index,
// the current pixel and any half-parsed chunk. A byte that only carries chunk
// payload is accepted and decoded, then the block is ready again. A byte that
// completes a pixel also passes store and emit, and an index lookup first
// waits on the registered read of the 64-entry colour index; a run emits its
// extra pixels in emit, each pixel holding while the output is stalled. The
// controller walks accept, decode, lookup, store and emit steps, so one byte is
// in flight at a time. Alpha is delivered only while channel_count is 4.
// ---------------------------------------------------------------------------
module qoi_chunk_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    qoi_byte_if.sink    byte_in,
    qoi_pixel_if.source pixel_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qoi_pkg::*;

    logic [CfgW-1:0] channel_count;
    qoi_cmd_t        cmd;
    qoi_sts_t        sts;

    // Configuration registers
    qoi_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .channel_count (channel_count)
    );

    // Sequencer
    qoi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_in.valid),
        .byte_ready  (byte_in.ready),
        .pixel_valid (pixel_out.valid),
        .pixel_ready (pixel_out.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Parser, pixel and index
    qoi_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (byte_in.data_byte),
        .image_start   (byte_in.image_start),
        .channel_count (channel_count),
        .cmd           (cmd),
        .sts           (sts),
        .red           (pixel_out.red),
        .green         (pixel_out.green),
        .blue          (pixel_out.blue),
        .alpha         (pixel_out.alpha),
        .alpha_used    (pixel_out.alpha_used),
        .last_of_run   (pixel_out.last_of_run)
    );

endmodule

### test/qoi_pixel_checker.sv
// ---------------------------------------------------------------------------
// QOI decoder pixel checker
// Watches the byte and pixel channels and the register port, predicts the
// decoded pixels and compares each pixel transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module qoi_pixel_checker #(
    parameter logic [2:0] ChannelCountAddr = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    qoi_byte_if         byte_mon,
    qoi_pixel_if        pixel_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import qoi_pkg::*;

    typedef struct packed {
        pixel_t px;
        logic   alpha_used;
        logic   last_of_run;
    } decoded_pixel_t;

    decoded_pixel_t  pixels_due[$];
    logic [CfgW-1:0] channels;
    pixel_t          pixel_now;
    pixel_t          palette [IndexDepth];
    qoi_kind_t       chunk_kind;
    logic [2:0]      payload_left;
    logic [31:0]     payload_bits;

    // Clear the colour index, the pixel and any half-parsed chunk
    task automatic start_image();
        foreach (palette[i])
            palette[i] = '0;
        pixel_now    = {24'd0, ALPHA_OPAQUE};
        chunk_kind   = KIND_NONE;
        payload_left = 3'd0;
        payload_bits = 32'd0;
    endtask

    // Store the pixel at its hash slot
    task automatic remember_pixel();
        int h;
        h = 3 * pixel_now.r + 5 * pixel_now.g + 7 * pixel_now.b + 11 * pixel_now.a;
        palette[h[IdxW-1:0]] = pixel_now;
    endtask

    task automatic emit_pixels(input int count);
        decoded_pixel_t d;
        for (int i = 0; i < count; i++)
        begin
            d.px          = pixel_now;
            d.alpha_used  = (channels == CH_RGBA);
            if (!d.alpha_used)
                d.px.a = 8'd0;
            d.last_of_run = (i == count - 1);
            pixels_due = {pixels_due, d};
        end
    endtask

    // Advance the decoder state by one byte transfer
    task automatic predict_byte(input logic [7:0] b, input logic new_image);
        logic [7:0] dg;
        logic [7:0] drg;
        logic [7:0] dbg;
        if (new_image)
            start_image();

        // Collect chunk payload; only the closing byte gives a pixel
        if (chunk_kind != KIND_NONE)
        begin
            payload_bits = {payload_bits[23:0], b};
            payload_left = payload_left - 3'd1;
            if (payload_left != 3'd0)
                return;
            case (chunk_kind)
                KIND_RGB:
                begin
                    pixel_now.r = payload_bits[23:16];
                    pixel_now.g = payload_bits[15:8];
                    pixel_now.b = payload_bits[7:0];
                end
                KIND_RGBA:
                    pixel_now = payload_bits;
                default:
                begin
                    dg  = 8'(payload_bits[13:8]) - 8'd32;
                    drg = 8'(payload_bits[7:4]) - 8'd8;
                    dbg = 8'(payload_bits[3:0]) - 8'd8;
                    pixel_now.r = pixel_now.r + dg + drg;
                    pixel_now.g = pixel_now.g + dg;
                    pixel_now.b = pixel_now.b + dg + dbg;
                end
            endcase
            chunk_kind   = KIND_NONE;
            payload_left = 3'd0;
            payload_bits = 32'd0;
            remember_pixel();
            emit_pixels(1);
            return;
        end

        if (b == OP_RGB)
        begin
            chunk_kind   = KIND_RGB;
            payload_left = 3'd3;
            payload_bits = 32'd0;
            return;
        end
        if (b == OP_RGBA)
        begin
            chunk_kind   = KIND_RGBA;
            payload_left = 3'd4;
            payload_bits = 32'd0;
            return;
        end

        case (b[7:6])
            TAG_INDEX:
                pixel_now = palette[b[5:0]];
            TAG_DIFF:
            begin
                pixel_now.r = pixel_now.r + 8'(b[5:4]) - 8'd2;
                pixel_now.g = pixel_now.g + 8'(b[3:2]) - 8'd2;
                pixel_now.b = pixel_now.b + 8'(b[1:0]) - 8'd2;
            end
            TAG_LUMA:
            begin
                chunk_kind   = KIND_LUMA;
                payload_left = 3'd1;
                payload_bits = {24'd0, b};
                return;
            end
            default: ;
        endcase
        remember_pixel();
        emit_pixels(b[7:6] == TAG_RUN ? int'(b[5:0]) + 1 : 1);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Compare a pixel transfer with the oldest prediction
    task automatic check_pixel();
        decoded_pixel_t d;
        if (pixels_due.size() == 0)
        begin
            $error("pixel transfer with none expected: r=%0d g=%0d b=%0d a=%0d",
                   pixel_mon.red, pixel_mon.green, pixel_mon.blue, pixel_mon.alpha);
            fail_count++;
            return;
        end
        d = pixels_due.pop_front();
        check_field("red", d.px.r, pixel_mon.red);
        check_field("green", d.px.g, pixel_mon.green);
        check_field("blue", d.px.b, pixel_mon.blue);
        check_field("alpha", d.px.a, pixel_mon.alpha);
        check_field("alpha_used", d.alpha_used, pixel_mon.alpha_used);
        check_field("last_of_run", d.last_of_run, pixel_mon.last_of_run);
    endtask

    // Take register writes first, then byte transfers, then pixel transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels = CH_RESET;
            start_image();
            pixels_due.delete();
            fail_count     = 0;
            pixels_pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ChannelCountAddr)
                channels = pwdata[CfgW-1:0];
            if (byte_mon.valid && byte_mon.ready)
                predict_byte(byte_mon.data_byte, byte_mon.image_start);
            if (pixel_mon.valid && pixel_mon.ready)
                check_pixel();
            pixels_pending = pixels_due.size();
        end
    end

endmodule

### test/tb_qoi_chunk_stream_decoder.sv
// ---------------------------------------------------------------------------
// QOI chunk stream decoder testbench
// Feeds directed and random chunk streams under several channel counts, with
// random stalls on both channels and one long output hold-off; the checker
// beside the block predicts and compares every decoded pixel.
// ---------------------------------------------------------------------------
module tb_qoi_chunk_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import qoi_pkg::*;

    localparam logic [2:0] ADDR_CHANNEL_COUNT = 3'd0;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 20;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pixels_pending;
    int bytes_sent;
    bit src_idle_on;
    bit sink_idle_on;
    bit hold_long;

    qoi_byte_if  byte_ch ();
    qoi_pixel_if pixel_ch ();

    qoi_chunk_stream_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .pixel_out (pixel_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    qoi_pixel_checker #(
        .ChannelCountAddr (ADDR_CHANNEL_COUNT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_mon       (byte_ch),
        .pixel_mon      (pixel_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Pixel receiver: random stall bursts, and one long hold-off on request
    initial
    begin
        pixel_ch.ready <= 1'b1;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 2) == 0)
            begin
                pixel_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Offer one byte, after an optional gap, and hold it until the transfer
    task automatic send_byte(input logic [7:0] value, input logic new_image);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= value;
        byte_ch.image_start <= new_image;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Payload bytes; now and then an image start breaks the chunk
    task automatic send_payload(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom), $urandom_range(0, 39) == 0);
    endtask

    task automatic send_random_chunk();
        int         pick;
        logic       new_image;
        logic [5:0] run_len;
        new_image = ($urandom_range(0, 29) == 0);
        pick      = $urandom_range(0, 99);
        if (pick < 15)
            send_byte({TAG_INDEX, 6'($urandom)}, new_image);
        else if (pick < 35)
            send_byte({TAG_DIFF, 6'($urandom)}, new_image);
        else if (pick < 55)
        begin
            send_byte({TAG_LUMA, 6'($urandom)}, new_image);
            send_payload(1);
        end
        else if (pick < 70)
        begin
            send_byte(OP_RGB, new_image);
            send_payload(3);
        end
        else if (pick < 80)
        begin
            send_byte(OP_RGBA, new_image);
            send_payload(4);
        end
        else if (pick < 92)
        begin
            // mostly short runs, with the odd long one
            run_len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 61))
                                                  : 6'($urandom_range(0, 5));
            send_byte({TAG_RUN, run_len}, new_image);
        end
        else
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic run_random(input int upto, input bit idling);
        src_idle_on  = idling;
        sink_idle_on = idling;
        while (bytes_sent < upto)
        begin
            if (idling && $urandom_range(0, 11) == 0)
                src_idle_on = !src_idle_on;
            if (idling && $urandom_range(0, 11) == 0)
                sink_idle_on = !sink_idle_on;
            send_random_chunk();
        end
    endtask

    // Drop valid, wait for every predicted pixel, then let the block settle
    task automatic drain();
        byte_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pixels_pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_channel_count(input logic [CfgW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CHANNEL_COUNT;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= 8'd0;
        byte_ch.image_start <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= 3'd0;
        pwdata              <= 32'd0;
        bytes_sent   = 0;
        hold_long    = 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every chunk kind at its extremes
        write_channel_count(CH_RGBA);
        send_byte({TAG_INDEX, 6'd0}, 1'b1);
        send_byte(OP_RGB, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(OP_RGBA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte({TAG_DIFF, 6'h00}, 1'b0);
        send_byte({TAG_DIFF, 6'h3F}, 1'b0);
        send_byte({TAG_LUMA, 6'h00}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte({TAG_LUMA, 6'h3F}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte({TAG_RUN, 6'd0}, 1'b0);
        send_byte({TAG_RUN, 6'd61}, 1'b0);
        send_byte({TAG_INDEX, 6'h3F}, 1'b0);
        // payload bytes that look like opcodes
        send_byte(OP_RGB, 1'b0);
        send_byte(OP_RGBA, 1'b0);
        send_byte(OP_RGB, 1'b0);
        send_byte(OP_RGBA, 1'b0);
        // image start in the middle of a chunk
        send_byte(OP_RGB, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte({TAG_DIFF, 6'h15}, 1'b1);
        drain();

        // Random phases across the channel counts, extremes included
        write_channel_count(3'd3);
        run_random(150, 1'b1);
        drain();
        write_channel_count(3'd0);
        run_random(200, 1'b1);
        drain();
        write_channel_count(3'd7);
        run_random(240, 1'b1);
        drain();

        // Hold the receiver off while long runs keep arriving
        write_channel_count(CH_RGBA);
        hold_long = 1'b1;
        send_byte({TAG_RUN, 6'd61}, 1'b0);
        send_byte({TAG_RUN, 6'd61}, 1'b0);
        send_byte({TAG_DIFF, 6'h2A}, 1'b0);
        send_byte({TAG_RUN, 6'd30}, 1'b0);
        run_random(370, 1'b1);

        // Closing stretch with no stalls on either side
        run_random(440, 1'b0);
        drain();

        if (fail_count == 0 && pixels_pending == 0)
            $display("qoi_chunk_stream_decoder: match");
        else
            $display("qoi_chunk_stream_decoder: mismatch");
        $finish;
    end

    // Give up if the decoder hangs
    initial
    begin
        #10_000_000;
        $display("qoi_chunk_stream_decoder: mismatch");
        $finish;
    end

endmodule
